// ----- rtl/sslod_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslod_pkg
// Shared types, constants and tables of the screen-size detail level selector.
// ----------------------------------------------------------------------------
package sslod_pkg;

   localparam int DEFAULT_MAX_LEVELS = 4;
   localparam int THRESHOLD_REGS     = 4;
   localparam int CORDIC_STEPS       = 24;
   localparam int X_W                = 43;
   localparam int Z_W                = 27;
   localparam int ANGLE_W            = 25;
   localparam int NUM_W              = 34;
   localparam int QUO_W              = 20;
   localparam int SIZE_W             = 20;
   localparam logic [26:0] ANGLE_TO_PIXELS = 27'd120158060;
   localparam logic [SIZE_W-1:0] SIZE_MAX  = '1;

   localparam logic [2:0] REG_FOV    = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_COUNT  = 3'd2;
   localparam logic [2:0] REG_THR0   = 3'd3;
   localparam logic [2:0] REG_THR1   = 3'd4;
   localparam logic [2:0] REG_THR2   = 3'd5;
   localparam logic [2:0] REG_THR3   = 3'd6;

   localparam logic [23:0] ATAN_TABLE [CORDIC_STEPS] = '{
      24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
      24'd262123, 24'd131069, 24'd65536, 24'd32768, 24'd16384, 24'd8192,
      24'd4096, 24'd2048, 24'd1024, 24'd512, 24'd256, 24'd128,
      24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2
   };

   typedef struct packed {
      logic [23:0] distance;
      logic [23:0] bounding_radius;
   } req_type;

   typedef struct packed {
      logic [1:0]        level;
      logic [SIZE_W-1:0] screen_size;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic zero_dist;
      logic zero_rad;
   } ctl_type;

endpackage

// ----- rtl/sslod_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslod_cordic
// Vectoring CORDIC, one register stage per rotation, giving the clamped angle.
// ----------------------------------------------------------------------------
module sslod_cordic import sslod_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl_in,
   input  logic [23:0]          distance,
   input  logic [23:0]          radius,
   output ctl_type              ctl_out,
   output logic [ANGLE_W-1:0]   angle
);

   function automatic logic signed [X_W-1:0] shift_tz(input logic signed [X_W-1:0] v,
                                                      input int s);
      logic signed [X_W-1:0] neg;
      neg = -v;
      shift_tz = v[X_W-1] ? -(neg >>> s) : (v >>> s);
   endfunction

   logic signed [X_W-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [X_W-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [Z_W-1:0] z_ff [CORDIC_STEPS+1];
   ctl_type               c_ff [CORDIC_STEPS+1];

   always_comb begin
      x_ff[0] = X_W'({distance, 16'd0});
      y_ff[0] = X_W'({radius, 16'd0});
      z_ff[0] = '0;
      c_ff[0] = ctl_in;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [X_W-1:0] dx, dy, x_in, y_in;
      logic signed [Z_W-1:0] z_in, a;
      always_comb begin
         dx = shift_tz(y_ff[i], i);
         dy = shift_tz(x_ff[i], i);
         a  = Z_W'(ATAN_TABLE[i]);
         if (!y_ff[i][X_W-1]) begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            z_in = z_ff[i] + a;
         end else begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            z_in = z_ff[i] - a;
         end
      end
      always_ff @(posedge clock) begin
         x_ff[i+1] <= x_in;
         y_ff[i+1] <= y_in;
         z_ff[i+1] <= z_in;
         if (reset) begin
            c_ff[i+1] <= '0;
         end else begin
            c_ff[i+1] <= c_ff[i];
         end
      end
   end

   assign ctl_out = c_ff[CORDIC_STEPS];
   assign angle   = z_ff[CORDIC_STEPS][Z_W-1] ? '0 : z_ff[CORDIC_STEPS][ANGLE_W-1:0];

endmodule

// ----- rtl/sslod_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslod_scale
// Turns the angle into a pixel numerator in two multiply stages and checks it
// against the saturation bound.
// ----------------------------------------------------------------------------
module sslod_scale import sslod_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl_in,
   input  logic [ANGLE_W-1:0]   angle,
   input  logic [13:0]          height,
   input  logic [15:0]          fov,
   output ctl_type              ctl_out,
   output logic [NUM_W-1:0]     num,
   output logic                 sat
);

   logic [51:0]      prod_ff;
   logic [49:0]      mult_ff;
   logic [NUM_W-1:0] num_ff;
   logic             sat_ff;
   ctl_type          c1_ff, c2_ff, c3_ff;
   logic [35:0]      t;
   logic [NUM_W-1:0] n_in;

   assign t    = prod_ff[51:16];
   assign n_in = mult_ff[49:16];

   always_ff @(posedge clock) begin
      prod_ff <= 52'(angle) * 52'(ANGLE_TO_PIXELS);
      mult_ff <= 50'(t) * 50'(height);
      num_ff  <= n_in;
      sat_ff  <= 36'(n_in) >= {fov, 20'd0};
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
      end else begin
         c1_ff <= ctl_in;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
      end
   end

   assign ctl_out = c3_ff;
   assign num     = num_ff;
   assign sat     = sat_ff;

endmodule

// ----- rtl/sslod_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslod_div
// Restoring divider by the field of view, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sslod_div import sslod_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl_in,
   input  logic [NUM_W-1:0]     num,
   input  logic                 sat_in,
   input  logic [15:0]          fov,
   output ctl_type              ctl_out,
   output logic [QUO_W-1:0]     quotient,
   output logic                 sat_out
);

   logic [NUM_W-1:0] r_ff [QUO_W+1];
   logic [QUO_W-1:0] q_ff [QUO_W+1];
   logic             s_ff [QUO_W+1];
   ctl_type          c_ff [QUO_W+1];

   always_comb begin
      r_ff[0] = num;
      q_ff[0] = '0;
      s_ff[0] = sat_in;
      c_ff[0] = ctl_in;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_bit
      localparam int B = QUO_W - 1 - k;
      logic [35:0] dvs;
      logic        ge;
      assign dvs = 36'(fov) << B;
      assign ge  = 36'(r_ff[k]) >= dvs;
      always_ff @(posedge clock) begin
         r_ff[k+1] <= ge ? NUM_W'(36'(r_ff[k]) - dvs) : r_ff[k];
         q_ff[k+1] <= q_ff[k] | (QUO_W'(ge) << B);
         s_ff[k+1] <= s_ff[k];
         if (reset) begin
            c_ff[k+1] <= '0;
         end else begin
            c_ff[k+1] <= c_ff[k];
         end
      end
   end

   assign ctl_out  = c_ff[QUO_W];
   assign quotient = q_ff[QUO_W];
   assign sat_out  = s_ff[QUO_W];

endmodule

// ----- rtl/screen_size_lod_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_size_lod_select
// Projects a bounding sphere to a pixel size and picks a detail level.
// ----------------------------------------------------------------------------
// One transaction can be started in every cycle; busy never rises. Each result
// appears on rsp_data with rsp_valid for a single cycle once it has passed
// through the 24 CORDIC stages, three scaling stages, the 20 divider stages
// and the output register. Results cannot be held off, so the receiver must
// take each one in the cycle it is shown.
// ----------------------------------------------------------------------------
module screen_size_lod_select import sslod_pkg::*; #(
   parameter int MAX_LEVELS = DEFAULT_MAX_LEVELS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type      req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  logic         csr_write,
   input  logic [2:0]   csr_index,
   input  logic [19:0]  csr_data
);

   localparam int LEVEL_LIMIT = (MAX_LEVELS < THRESHOLD_REGS) ? MAX_LEVELS : THRESHOLD_REGS;

   logic [15:0]       fov_ff;
   logic [13:0]       height_ff;
   logic [2:0]        count_ff;
   logic [SIZE_W-1:0] thr_ff [THRESHOLD_REGS];

   ctl_type           ctl_a, ctl_b, ctl_c;
   logic [ANGLE_W-1:0] angle;
   logic [NUM_W-1:0]  num;
   logic              sat_b, sat_c;
   logic [QUO_W-1:0]  quotient;
   logic [2:0]        count_eff;
   logic [SIZE_W-1:0] size;
   logic [1:0]        level;
   logic              found;
   logic              valid_ff;
   rsp_type           rsp_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fov_ff    <= 16'd15360;
         height_ff <= 14'd1080;
         count_ff  <= 3'd1;
         for (int i = 0; i < THRESHOLD_REGS; i++) begin
            thr_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FOV:    fov_ff    <= csr_data[15:0];
            REG_HEIGHT: height_ff <= csr_data[13:0];
            REG_COUNT:  count_ff  <= csr_data[2:0];
            REG_THR0:   thr_ff[0] <= csr_data;
            REG_THR1:   thr_ff[1] <= csr_data;
            REG_THR2:   thr_ff[2] <= csr_data;
            REG_THR3:   thr_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   sslod_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  ('{valid: start & ~busy,
                  zero_dist: req_data.distance == '0,
                  zero_rad: req_data.bounding_radius == '0}),
      .distance(req_data.distance),
      .radius  (req_data.bounding_radius),
      .ctl_out (ctl_a),
      .angle   (angle)
   );

   sslod_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .ctl_in (ctl_a),
      .angle  (angle),
      .height (height_ff),
      .fov    (fov_ff),
      .ctl_out(ctl_b),
      .num    (num),
      .sat    (sat_b)
   );

   sslod_div u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (ctl_b),
      .num     (num),
      .sat_in  (sat_b),
      .fov     (fov_ff),
      .ctl_out (ctl_c),
      .quotient(quotient),
      .sat_out (sat_c)
   );

   always_comb begin
      if (count_ff == 3'd0) begin
         count_eff = 3'd1;
      end else if (32'(count_ff) > LEVEL_LIMIT) begin
         count_eff = 3'(LEVEL_LIMIT);
      end else begin
         count_eff = count_ff;
      end

      priority if (ctl_c.zero_dist) begin
         size = SIZE_W'({height_ff, 4'd0});
      end else if (ctl_c.zero_rad) begin
         size = '0;
      end else if (sat_c) begin
         size = SIZE_MAX;
      end else begin
         size = quotient;
      end

      level = 2'(count_eff - 3'd1);
      found = 1'b0;
      for (int i = 0; i < THRESHOLD_REGS; i++) begin
         if (!found && 3'(i) < count_eff && size >= thr_ff[i]) begin
            level = 2'(i);
            found = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= '{level: level, screen_size: size};
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_c.valid;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##48 rsp_valid)
      else $error("transaction result missing after pipeline latency");

   a_level_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.level != 2'd0 |-> rsp_data.screen_size < thr_ff[0])
      else $error("level zero skipped although its threshold was met");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 3'(rsp_data.level) < count_eff)
      else $error("level beyond the levels in use");

endmodule
